// ===== src/bfa_pkg.sv =====
// Package for the best-fit deferred-free allocator.
// Holds the request and result word types, status and opcode codes, and the sequencer states.
// Used by best_fit_deferred_free_allocator and the testbench; depends on nothing.
`default_nettype none

package bfa_pkg;

  localparam logic [15:0] MIN_ALIGN = 16'd4;
  localparam logic [31:0] DEFAULT_CAPACITY = 32'd4194304;
  localparam logic [7:0] DEFAULT_FRAMES = 8'd3;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_RELEASE = 2'd1,
    OP_FLUSH = 2'd2,
    OP_NONE = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_KEPT = 3'd0,
    ST_GRANT = 3'd1,
    ST_NOFIT = 3'd2,
    ST_FULL = 3'd3,
    ST_DONE = 3'd4
  } status_t;

  typedef enum logic {
    REG_FRAMES = 1'b0,
    REG_CAPACITY = 1'b1
  } reg_index_t;

  typedef enum logic [1:0] {
    CTX_PRE,
    CTX_MAIN,
    CTX_FLUSH
  } rel_ctx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_REL_TEST,
    S_FR_SCAN,
    S_FR_APPLY,
    S_PQ_SHIFT,
    S_PK_FIND,
    S_PK_SHIFT,
    S_FIT_START,
    S_FIT_WAIT,
    S_FIT_EVAL,
    S_GRANT,
    S_RESULT
  } state_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic [31:0] current_frame;
    logic [31:0] size_bytes;
    logic [15:0] alignment;
    logic held_valid;
    logic [31:0] held_start;
    logic [31:0] held_size;
    logic [31:0] held_last_frame;
  } in_word_t;

  typedef struct packed {
    logic [2:0] status;
    logic [31:0] granted_offset;
    logic [15:0] pre_padding;
  } out_word_t;

endpackage

`default_nettype wire

// ===== src/best_fit_deferred_free_allocator.sv =====
// Top level of the best-fit deferred-free allocator: sequencer, free and parked tables.
// Depends on bfa_pkg and bfa_rem.
//
// A request word is taken when start is high and busy is low. The block then
// works on it alone and raises done for exactly one cycle with the result word.
// The receiver cannot stall, so the result is simply dropped after that cycle.
// Each free-table entry visited for best fit passes S_FIT_START, which starts the
// shared bit-serial remainder unit, S_FIT_WAIT, which waits on it, and S_FIT_EVAL;
// an allocate's time so grows with free_count, plus the parking and release work.
// Parking a block scans the parked table for its place and shifts the queue up;
// freeing one parked block scans the free table for merges and shifts the queue.
// A request with nothing to do gives its result in the cycle after it is taken;
// an empty flush passes through S_REL_TEST first.
// Configuration writes are taken at any edge with cfg_we high and must only
// come while the block is idle. Writing pool_capacity restarts the pool as one
// free block, none if zero, with an empty parked table. Synchronous reset gives
// frames_in_flight 3 and a 4 MiB pool; no clearing pass is needed.
`default_nettype none

module best_fit_deferred_free_allocator #(
  parameter int FREE_ENTRIES = 32,
  parameter int PARKED_ENTRIES = 32
) (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  output logic busy,
  input wire bfa_pkg::in_word_t request,
  output logic done,
  output bfa_pkg::out_word_t result,
  input wire logic cfg_we,
  input wire logic cfg_index,
  input wire logic [31:0] cfg_data
);

  localparam int FCW = $clog2(FREE_ENTRIES + 1);
  localparam int FIW = $clog2(FREE_ENTRIES);
  localparam int PCW = $clog2(PARKED_ENTRIES + 1);
  localparam int PIW = $clog2(PARKED_ENTRIES);
  localparam logic [FCW-1:0] FREE_MAX = FCW'(FREE_ENTRIES);
  localparam logic [PCW-1:0] PARK_MAX = PCW'(PARKED_ENTRIES);
  localparam logic [32:0] MAX32 = 33'h0_FFFF_FFFF;

  logic [31:0] fo [FREE_ENTRIES];
  logic [31:0] fs [FREE_ENTRIES];
  logic [31:0] ps [PARKED_ENTRIES];
  logic [31:0] pz [PARKED_ENTRIES];
  logic [31:0] pf [PARKED_ENTRIES];

  logic [7:0] frames_in_flight;
  logic [FCW-1:0] free_count;
  logic [PCW-1:0] parked_count;

  bfa_pkg::state_t state, state_next;
  bfa_pkg::rel_ctx_t ctx;
  bfa_pkg::in_word_t req;
  bfa_pkg::out_word_t res;
  logic [15:0] align_eff;

  logic [FCW-1:0] fi;
  logic [PCW-1:0] pj;
  logic [PCW-1:0] pos;
  logic lv, rv, bv;
  logic [FIW-1:0] li, ri, bi;
  logic [15:0] bpad;

  logic rem_go, rem_done;
  logic [15:0] rem_val;

  logic [FIW-1:0] fidx, flast;
  logic [31:0] fo_i, fs_i;
  logic [32:0] e_i, ext_end, e_r, merged_lr;
  logic left_hit, right_hit, both_ok;
  logic rel_finish, rel_ok, front_young;
  logic held_old, held_park;
  logic [15:0] pad_i;
  logic fit_i;
  logic [31:0] grant_off, grant_size;
  logic [31:0] age_front, age_held;

  bfa_rem u_rem (
    .clk(clk),
    .rst(rst),
    .go(rem_go),
    .dividend(fo_i),
    .divisor(align_eff),
    .done(rem_done),
    .rem(rem_val)
  );

  always_comb begin
    fidx = fi[FIW-1:0];
    flast = FIW'(free_count - FCW'(1));
    fo_i = fo[fidx];
    fs_i = fs[fidx];
    e_i = {1'b0, fo_i} + {1'b0, fs_i};
    ext_end = {1'b0, ps[0]} + {1'b0, pz[0]};
    left_hit = !lv && (e_i == {1'b0, ps[0]}) && ((ext_end - {1'b0, fo_i}) <= MAX32);
    right_hit = !rv && ({1'b0, fo_i} == ext_end) && ((e_i - {1'b0, ps[0]}) <= MAX32);
    e_r = {1'b0, fo[ri]} + {1'b0, fs[ri]};
    merged_lr = e_r - {1'b0, fo[li]};
    both_ok = lv && rv && (merged_lr <= MAX32);
    age_front = req.current_frame - pf[0];
    front_young = (ctx != bfa_pkg::CTX_FLUSH) && (age_front < {24'd0, frames_in_flight});
    age_held = request.current_frame - request.held_last_frame;
    held_old = request.held_valid && (age_held >= {24'd0, frames_in_flight});
    held_park = request.held_valid && (request.held_size != 32'd0);
    pad_i = (rem_val == 16'd0) ? 16'd0 : align_eff - rem_val;
    fit_i = ({17'd0, pad_i} + {1'b0, req.size_bytes}) <= {1'b0, fs_i};
    grant_off = fo[bi] + {16'd0, bpad};
    grant_size = fs[bi] - {16'd0, bpad} - req.size_bytes;
    rel_finish = 1'b0;
    rel_ok = 1'b1;
    if (state == bfa_pkg::S_REL_TEST && (parked_count == '0 || front_young)) begin
      rel_finish = 1'b1;
    end
    if (state == bfa_pkg::S_FR_APPLY && !both_ok && !lv && !rv && free_count >= FREE_MAX) begin
      rel_finish = 1'b1;
      rel_ok = 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    rem_go = 1'b0;
    case (state)
      bfa_pkg::S_IDLE: begin
        if (start) begin
          case (request.opcode)
            bfa_pkg::OP_ALLOC: begin
              if (held_old) begin
                state_next = bfa_pkg::S_RESULT;
              end else if (held_park && parked_count >= PARK_MAX) begin
                state_next = bfa_pkg::S_REL_TEST;
              end else if (held_park) begin
                state_next = bfa_pkg::S_PK_FIND;
              end else begin
                state_next = bfa_pkg::S_REL_TEST;
              end
            end
            bfa_pkg::OP_RELEASE: begin
              if (held_park && parked_count < PARK_MAX) begin
                state_next = bfa_pkg::S_PK_FIND;
              end else begin
                state_next = bfa_pkg::S_RESULT;
              end
            end
            bfa_pkg::OP_FLUSH: state_next = bfa_pkg::S_REL_TEST;
            default: state_next = bfa_pkg::S_RESULT;
          endcase
        end
      end
      bfa_pkg::S_REL_TEST: begin
        if (!rel_finish) begin
          state_next = (pz[0] == 32'd0) ? bfa_pkg::S_PQ_SHIFT : bfa_pkg::S_FR_SCAN;
        end
      end
      bfa_pkg::S_FR_SCAN: begin
        if (fi >= free_count) begin
          state_next = bfa_pkg::S_FR_APPLY;
        end
      end
      bfa_pkg::S_FR_APPLY: begin
        if (!rel_finish) begin
          state_next = bfa_pkg::S_PQ_SHIFT;
        end
      end
      bfa_pkg::S_PQ_SHIFT: begin
        if (pj >= parked_count) begin
          state_next = bfa_pkg::S_REL_TEST;
        end
      end
      bfa_pkg::S_PK_FIND: begin
        if (!(pos < parked_count && pf[pos[PIW-1:0]] < req.held_last_frame)) begin
          state_next = bfa_pkg::S_PK_SHIFT;
        end
      end
      bfa_pkg::S_PK_SHIFT: begin
        if (pj <= pos) begin
          state_next = (req.opcode == bfa_pkg::OP_ALLOC) ? bfa_pkg::S_REL_TEST
                                                        : bfa_pkg::S_RESULT;
        end
      end
      bfa_pkg::S_FIT_START: begin
        if (fi >= free_count) begin
          state_next = bv ? bfa_pkg::S_GRANT : bfa_pkg::S_RESULT;
        end else begin
          rem_go = 1'b1;
          state_next = bfa_pkg::S_FIT_WAIT;
        end
      end
      bfa_pkg::S_FIT_WAIT: begin
        if (rem_done) begin
          state_next = bfa_pkg::S_FIT_EVAL;
        end
      end
      bfa_pkg::S_FIT_EVAL: state_next = bfa_pkg::S_FIT_START;
      bfa_pkg::S_GRANT: state_next = bfa_pkg::S_RESULT;
      bfa_pkg::S_RESULT: state_next = bfa_pkg::S_IDLE;
      default: state_next = bfa_pkg::S_IDLE;
    endcase
    if (rel_finish) begin
      case (ctx)
        bfa_pkg::CTX_PRE: begin
          state_next = (parked_count >= PARK_MAX) ? bfa_pkg::S_RESULT : bfa_pkg::S_PK_FIND;
        end
        bfa_pkg::CTX_MAIN: state_next = bfa_pkg::S_FIT_START;
        default: state_next = bfa_pkg::S_RESULT;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bfa_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_flight <= bfa_pkg::DEFAULT_FRAMES;
      free_count <= FCW'(1);
      parked_count <= '0;
      fo[0] <= 32'd0;
      fs[0] <= bfa_pkg::DEFAULT_CAPACITY;
      ctx <= bfa_pkg::CTX_MAIN;
    end else begin
      if (cfg_we) begin
        if (cfg_index == bfa_pkg::REG_FRAMES) begin
          frames_in_flight <= cfg_data[7:0];
        end else begin
          fo[0] <= 32'd0;
          fs[0] <= cfg_data;
          free_count <= (cfg_data != 32'd0) ? FCW'(1) : '0;
          parked_count <= '0;
        end
      end
      case (state)
        bfa_pkg::S_IDLE: begin
          if (start) begin
            req <= request;
            align_eff <= (request.alignment < bfa_pkg::MIN_ALIGN) ? bfa_pkg::MIN_ALIGN
                                                                  : request.alignment;
            res <= '{status: bfa_pkg::ST_DONE, granted_offset: 32'd0, pre_padding: 16'd0};
            pos <= '0;
            case (request.opcode)
              bfa_pkg::OP_ALLOC: begin
                if (held_old) begin
                  res.status <= bfa_pkg::ST_KEPT;
                end else if (held_park && parked_count >= PARK_MAX) begin
                  ctx <= bfa_pkg::CTX_PRE;
                end else begin
                  ctx <= bfa_pkg::CTX_MAIN;
                end
              end
              bfa_pkg::OP_RELEASE: begin
                if (held_park && parked_count >= PARK_MAX) begin
                  res.status <= bfa_pkg::ST_FULL;
                end
              end
              bfa_pkg::OP_FLUSH: ctx <= bfa_pkg::CTX_FLUSH;
              default: ctx <= bfa_pkg::CTX_MAIN;
            endcase
          end
        end
        bfa_pkg::S_REL_TEST: begin
          fi <= '0;
          lv <= 1'b0;
          rv <= 1'b0;
          pj <= PCW'(1);
        end
        bfa_pkg::S_FR_SCAN: begin
          if (fi < free_count) begin
            if (left_hit) begin
              lv <= 1'b1;
              li <= fidx;
            end
            if (right_hit) begin
              rv <= 1'b1;
              ri <= fidx;
            end
            fi <= fi + FCW'(1);
          end
        end
        bfa_pkg::S_FR_APPLY: begin
          fi <= '0;
          if (both_ok) begin
            fs[li] <= merged_lr[31:0];
            fo[ri] <= fo[flast];
            fs[ri] <= (li == flast) ? merged_lr[31:0] : fs[flast];
            free_count <= free_count - FCW'(1);
          end else if (lv) begin
            fs[li] <= 32'(ext_end - {1'b0, fo[li]});
          end else if (rv) begin
            fo[ri] <= ps[0];
            fs[ri] <= 32'(e_r - {1'b0, ps[0]});
          end else if (free_count < FREE_MAX) begin
            fo[free_count[FIW-1:0]] <= ps[0];
            fs[free_count[FIW-1:0]] <= pz[0];
            free_count <= free_count + FCW'(1);
          end
        end
        bfa_pkg::S_PQ_SHIFT: begin
          if (pj < parked_count) begin
            ps[PIW'(pj - PCW'(1))] <= ps[pj[PIW-1:0]];
            pz[PIW'(pj - PCW'(1))] <= pz[pj[PIW-1:0]];
            pf[PIW'(pj - PCW'(1))] <= pf[pj[PIW-1:0]];
            pj <= pj + PCW'(1);
          end else begin
            parked_count <= parked_count - PCW'(1);
          end
        end
        bfa_pkg::S_PK_FIND: begin
          if (pos < parked_count && pf[pos[PIW-1:0]] < req.held_last_frame) begin
            pos <= pos + PCW'(1);
          end else begin
            pj <= parked_count;
          end
        end
        bfa_pkg::S_PK_SHIFT: begin
          if (pj > pos) begin
            ps[pj[PIW-1:0]] <= ps[PIW'(pj - PCW'(1))];
            pz[pj[PIW-1:0]] <= pz[PIW'(pj - PCW'(1))];
            pf[pj[PIW-1:0]] <= pf[PIW'(pj - PCW'(1))];
            pj <= pj - PCW'(1);
          end else begin
            ps[pos[PIW-1:0]] <= req.held_start;
            pz[pos[PIW-1:0]] <= req.held_size;
            pf[pos[PIW-1:0]] <= req.held_last_frame;
            parked_count <= parked_count + PCW'(1);
            ctx <= bfa_pkg::CTX_MAIN;
          end
        end
        bfa_pkg::S_FIT_START: begin
          if (fi >= free_count && !bv) begin
            res.status <= bfa_pkg::ST_NOFIT;
          end
        end
        bfa_pkg::S_FIT_EVAL: begin
          if (fit_i && (!bv || fs_i < fs[bi])) begin
            bv <= 1'b1;
            bi <= fidx;
            bpad <= pad_i;
          end
          fi <= fi + FCW'(1);
        end
        bfa_pkg::S_GRANT: begin
          res.status <= bfa_pkg::ST_GRANT;
          res.granted_offset <= grant_off;
          res.pre_padding <= bpad;
          if (grant_size == 32'd0) begin
            fo[bi] <= fo[flast];
            fs[bi] <= fs[flast];
            free_count <= free_count - FCW'(1);
          end else begin
            fo[bi] <= grant_off + req.size_bytes;
            fs[bi] <= grant_size;
          end
        end
        default: begin
        end
      endcase
      if (rel_finish) begin
        bv <= 1'b0;
        pos <= '0;
        case (ctx)
          bfa_pkg::CTX_PRE: begin
            if (parked_count >= PARK_MAX) begin
              res.status <= bfa_pkg::ST_FULL;
            end
          end
          bfa_pkg::CTX_FLUSH: begin
            if (!rel_ok) begin
              res.status <= bfa_pkg::ST_FULL;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  assign busy = (state != bfa_pkg::S_IDLE);
  assign done = (state == bfa_pkg::S_RESULT);
  assign result = res;

endmodule

`default_nettype wire

// ===== src/bfa_rem.sv =====
// Bit-serial remainder unit: 32-bit dividend modulo a 16-bit divisor, one bit per cycle.
// Standalone; used by best_fit_deferred_free_allocator for alignment padding.
`default_nettype none

module bfa_rem (
  input wire logic clk,
  input wire logic rst,
  input wire logic go,
  input wire logic [31:0] dividend,
  input wire logic [15:0] divisor,
  output logic done,
  output logic [15:0] rem
);

  logic [31:0] shreg;
  logic [16:0] part;
  logic [5:0] count;
  logic running;
  logic [16:0] trial;

  always_comb begin
    trial = {part[15:0], shreg[31]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        running <= 1'b1;
        count <= '0;
        shreg <= dividend;
        part <= '0;
      end else if (running) begin
        shreg <= {shreg[30:0], 1'b0};
        if (trial >= {1'b0, divisor}) begin
          part <= trial - {1'b0, divisor};
        end else begin
          part <= trial;
        end
        count <= count + 6'd1;
        if (count == 6'd31) begin
          running <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rem = part[15:0];

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// Self-checking testbench for best_fit_deferred_free_allocator: directed and random request words,
// random sender gaps and configuration phases, checked against an in-order allocator predictor.
// Depends on bfa_pkg and the allocator RTL.
`default_nettype none

class alloc_scoreboard;
  bit [7:0] frames_safe;
  bit [31:0] capacity;
  bit [31:0] free_off [32];
  bit [31:0] free_len [32];
  int free_num;
  bit [31:0] park_start [32];
  bit [31:0] park_len [32];
  bit [31:0] park_frame [32];
  int park_num;
  bfa_pkg::out_word_t awaited [$];
  int errors;
  int checked;
  int grants;
  int no_fits;
  int fulls;

  function new();
    frames_safe = bfa_pkg::DEFAULT_FRAMES;
    capacity = bfa_pkg::DEFAULT_CAPACITY;
    errors = 0;
    checked = 0;
    grants = 0;
    no_fits = 0;
    fulls = 0;
    restart_pool();
  endfunction

  function void restart_pool();
    free_off[0] = 0;
    free_len[0] = capacity;
    free_num = (capacity != 0) ? 1 : 0;
    park_num = 0;
  endfunction

  function void write_reg(bfa_pkg::reg_index_t idx, bit [31:0] v);
    if (idx == bfa_pkg::REG_FRAMES) begin
      frames_safe = v[7:0];
    end else begin
      capacity = v;
      restart_pool();
    end
  endfunction

  function void drop_free(int i);
    if (i >= free_num) return;
    free_num--;
    free_off[i] = free_off[free_num];
    free_len[i] = free_len[free_num];
  endfunction

  function bit free_extent(bit [31:0] s, bit [31:0] z);
    longint unsigned ext_end;
    longint unsigned e;
    longint unsigned lim;
    int left;
    int right;
    ext_end = 64'(s) + z;
    lim = 64'hFFFF_FFFF;
    left = -1;
    right = -1;
    if (z == 0) return 1;
    for (int i = 0; i < free_num; i++) begin
      e = 64'(free_off[i]) + free_len[i];
      if (left < 0 && e == s && ext_end - free_off[i] <= lim) left = i;
      if (right < 0 && 64'(free_off[i]) == ext_end && e - s <= lim) right = i;
    end
    if (left >= 0 && right >= 0) begin
      e = 64'(free_off[right]) + free_len[right];
      if (e - free_off[left] <= lim) begin
        free_len[left] = 32'(e - free_off[left]);
        drop_free(right);
        return 1;
      end
    end
    if (left >= 0) begin
      free_len[left] = 32'(ext_end - free_off[left]);
      return 1;
    end
    if (right >= 0) begin
      e = 64'(free_off[right]) + free_len[right];
      free_off[right] = s;
      free_len[right] = 32'(e - s);
      return 1;
    end
    if (free_num >= 32) return 0;
    free_off[free_num] = s;
    free_len[free_num] = z;
    free_num++;
    return 1;
  endfunction

  function bit park(bit [31:0] s, bit [31:0] z, bit [31:0] f);
    int pos;
    pos = 0;
    if (z == 0) return 1;
    if (park_num >= 32) return 0;
    while (pos < park_num && park_frame[pos] < f) pos++;
    for (int i = park_num; i > pos; i--) begin
      park_start[i] = park_start[i - 1];
      park_len[i] = park_len[i - 1];
      park_frame[i] = park_frame[i - 1];
    end
    park_start[pos] = s;
    park_len[pos] = z;
    park_frame[pos] = f;
    park_num++;
    return 1;
  endfunction

  function bit release_parked(bit [31:0] now, bit all);
    bit [31:0] age;
    while (park_num > 0) begin
      age = now - park_frame[0];
      if (!all && age < 32'(frames_safe)) break;
      if (!free_extent(park_start[0], park_len[0])) return 0;
      for (int i = 1; i < park_num; i++) begin
        park_start[i - 1] = park_start[i];
        park_len[i - 1] = park_len[i];
        park_frame[i - 1] = park_frame[i];
      end
      park_num--;
    end
    return 1;
  endfunction

  function bfa_pkg::out_word_t note_request(bfa_pkg::in_word_t w);
    bfa_pkg::out_word_t r;
    longint unsigned align;
    longint unsigned off;
    longint unsigned al;
    longint unsigned grant;
    longint unsigned pad;
    bit [31:0] age;
    bit ok;
    bit dummy;
    int best;
    r = '0;
    r.status = bfa_pkg::ST_DONE;
    align = (w.alignment < bfa_pkg::MIN_ALIGN) ? 64'(bfa_pkg::MIN_ALIGN) : 64'(w.alignment);
    age = w.current_frame - w.held_last_frame;
    if (w.opcode == bfa_pkg::OP_ALLOC) begin
      if (w.held_valid && age >= 32'(frames_safe)) begin
        r.status = bfa_pkg::ST_KEPT;
      end else begin
        ok = 1;
        if (w.held_valid && w.held_size != 0 && park_num >= 32) begin
          dummy = release_parked(w.current_frame, 0);
          if (park_num >= 32) ok = 0;
        end
        if (!ok) begin
          r.status = bfa_pkg::ST_FULL;
        end else begin
          best = -1;
          if (w.held_valid) dummy = park(w.held_start, w.held_size, w.held_last_frame);
          dummy = release_parked(w.current_frame, 0);
          for (int i = 0; i < free_num; i++) begin
            off = free_off[i];
            al = ((off + align - 1) / align) * align;
            if ((al - off) + w.size_bytes <= free_len[i] &&
                (best < 0 || free_len[i] < free_len[best]))
              best = i;
          end
          if (best < 0) begin
            r.status = bfa_pkg::ST_NOFIT;
          end else begin
            off = free_off[best];
            grant = ((off + align - 1) / align) * align;
            pad = grant - off;
            free_off[best] = 32'(grant + w.size_bytes);
            free_len[best] = free_len[best] - 32'(pad) - w.size_bytes;
            if (free_len[best] == 0) drop_free(best);
            r.status = bfa_pkg::ST_GRANT;
            r.granted_offset = 32'(grant);
            r.pre_padding = 16'(pad);
          end
        end
      end
    end else if (w.opcode == bfa_pkg::OP_RELEASE) begin
      if (w.held_valid && !park(w.held_start, w.held_size, w.held_last_frame))
        r.status = bfa_pkg::ST_FULL;
    end else if (w.opcode == bfa_pkg::OP_FLUSH) begin
      if (!release_parked(w.current_frame, 1)) r.status = bfa_pkg::ST_FULL;
    end
    awaited.insert(awaited.size(), r);
    return r;
  endfunction

  task report(string msg);
    errors++;
    $display("MISMATCH: %s", msg);
  endtask

  task check_result(bfa_pkg::out_word_t r);
    bfa_pkg::out_word_t e;
    if (awaited.size() == 0) begin
      report($sformatf("unexpected word status=%0d", r.status));
      return;
    end
    e = awaited.pop_front();
    checked++;
    if (r.status == bfa_pkg::ST_GRANT) grants++;
    if (r.status == bfa_pkg::ST_NOFIT) no_fits++;
    if (r.status == bfa_pkg::ST_FULL) fulls++;
    if (r.status !== e.status)
      report($sformatf("word %0d status %0d, want %0d", checked, r.status, e.status));
    if (r.granted_offset !== e.granted_offset)
      report($sformatf("word %0d offset %h, want %h", checked, r.granted_offset,
                       e.granted_offset));
    if (r.pre_padding !== e.pre_padding)
      report($sformatf("word %0d padding %h, want %h", checked, r.pre_padding,
                       e.pre_padding));
  endtask
endclass

typedef struct {
  bit [31:0] blk_start;
  bit [31:0] blk_size;
  bit [31:0] blk_frame;
} block_t;

module tb;
  localparam int IDLE_LIMIT = 40000;

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic busy;
  bfa_pkg::in_word_t request = '0;
  logic done;
  bfa_pkg::out_word_t result;
  logic cfg_we = 0;
  logic cfg_index = 0;
  logic [31:0] cfg_data = '0;

  alloc_scoreboard sb;
  block_t owned [$];
  bit [31:0] now;
  int burst_left;
  int n_sent;
  int idle_cycles;

  best_fit_deferred_free_allocator dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .request(request),
    .done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  always @(negedge clk) begin
    if (!rst) begin
      if (done) sb.check_result(result);
      if (done || (start && !busy)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles > IDLE_LIMIT) begin
        $display("Timeout: no word moved for %0d cycles", IDLE_LIMIT);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  task automatic send_word(input bfa_pkg::in_word_t w, output bfa_pkg::out_word_t p);
    request <= w;
    start <= 1;
    do @(negedge clk); while (busy);
    @(posedge clk);
    p = sb.note_request(w);
    n_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      start <= 0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
      burst_left = $urandom_range(1, 40);
    end
  endtask

  task automatic wait_idle();
    start <= 0;
    @(posedge clk);
    while (sb.awaited.size() != 0) @(posedge clk);
    do @(negedge clk); while (busy);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input bfa_pkg::reg_index_t idx, input bit [31:0] v);
    @(posedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 0;
    sb.write_reg(idx, v);
    owned.delete();
  endtask

  task automatic direct(input bfa_pkg::opcode_t op, input bit [31:0] f, input bit [31:0] sz,
                        input bit [15:0] al, input bit hv, input bit [31:0] hs,
                        input bit [31:0] hz, input bit [31:0] hf);
    bfa_pkg::in_word_t w;
    bfa_pkg::out_word_t p;
    w.opcode = op;
    w.current_frame = f;
    w.size_bytes = sz;
    w.alignment = al;
    w.held_valid = hv;
    w.held_start = hs;
    w.held_size = hz;
    w.held_last_frame = hf;
    send_word(w, p);
  endtask

  function automatic bit [31:0] pick_size();
    bit [31:0] lim;
    lim = sb.capacity >> 4;
    if (lim < 8) lim = 8;
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return 0;
      2: return sb.capacity;
      default: return $urandom_range(1, lim);
    endcase
  endfunction

  function automatic bit [15:0] pick_align();
    case ($urandom_range(0, 5))
      0: return 16'($urandom_range(0, 65535));
      1: return 16'(1 << $urandom_range(0, 15));
      default: return 16'($urandom_range(1, 16));
    endcase
  endfunction

  task automatic random_word(input int release_bias);
    bfa_pkg::in_word_t w;
    bfa_pkg::out_word_t p;
    int r;
    int idx;
    idx = -1;
    if ($urandom_range(0, 2) == 0) now += 32'($urandom_range(1, 3));
    w = '0;
    w.current_frame = now;
    w.alignment = pick_align();
    r = $urandom_range(0, 99);
    if (owned.size() > 40) r = 60;
    if (r < 50 - release_bias) begin
      w.opcode = bfa_pkg::OP_ALLOC;
      w.size_bytes = pick_size();
      if (owned.size() > 0 && $urandom_range(0, 1)) idx = $urandom_range(0, owned.size() - 1);
    end else if (r < 80) begin
      w.opcode = bfa_pkg::OP_RELEASE;
      if (owned.size() > 0) idx = $urandom_range(0, owned.size() - 1);
    end else if (r < 85) begin
      w.opcode = bfa_pkg::OP_FLUSH;
    end else begin
      w.current_frame = $urandom;
      w.size_bytes = $urandom;
      w.alignment = 16'($urandom);
      w.held_valid = 1'($urandom_range(0, 1));
      w.held_start = $urandom;
      w.held_size = $urandom;
      w.held_last_frame = $urandom;
      w.opcode = bfa_pkg::opcode_t'($urandom_range(0, 3));
    end
    if (idx >= 0) begin
      w.held_valid = 1;
      w.held_start = owned[idx].blk_start;
      w.held_size = owned[idx].blk_size;
      w.held_last_frame = owned[idx].blk_frame;
    end
    send_word(w, p);
    if (r >= 85) return;
    if (idx >= 0) begin
      if (p.status == bfa_pkg::ST_KEPT) begin
        owned[idx].blk_frame = now;
      end else if (p.status != bfa_pkg::ST_FULL) begin
        owned.delete(idx);
      end
    end
    if (p.status == bfa_pkg::ST_GRANT)
      owned.insert(owned.size(), '{p.granted_offset - 32'(p.pre_padding),
                                   32'(p.pre_padding) + w.size_bytes, now});
  endtask

  initial begin
    sb = new();
    n_sent = 0;
    idle_cycles = 0;
    burst_left = 10;
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    direct(bfa_pkg::OP_ALLOC, 100, 0, 1, 0, 0, 0, 0);
    direct(bfa_pkg::OP_ALLOC, 100, 100, 3, 0, 0, 0, 0);
    direct(bfa_pkg::OP_ALLOC, 100, 64, 16'hFFFF, 0, 0, 0, 0);
    direct(bfa_pkg::OP_ALLOC, 100, 32'hFFFF_FFFF, 0, 0, 0, 0, 0);
    direct(bfa_pkg::OP_ALLOC, 100, 40, 8, 1, 0, 100, 90);
    direct(bfa_pkg::OP_ALLOC, 100, 40, 8, 1, 0, 100, 99);
    direct(bfa_pkg::OP_RELEASE, 100, 0, 4, 0, 0, 0, 0);
    direct(bfa_pkg::OP_RELEASE, 100, 0, 4, 1, 200, 0, 100);
    direct(bfa_pkg::OP_RELEASE, 100, 0, 4, 1, 4096, 512, 100);
    direct(bfa_pkg::OP_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 1, 32'hFFFF_FFFF,
           32'hFFFF_FFFF, 32'hFFFF_FFFF);
    direct(bfa_pkg::OP_FLUSH, 101, 0, 4, 0, 0, 0, 0);
    direct(bfa_pkg::OP_ALLOC, 1, 16, 4, 1, 8192, 256, 32'hFFFF_FFFF);
    direct(bfa_pkg::OP_ALLOC, 5, 16, 4, 0, 0, 0, 0);
    direct(bfa_pkg::OP_RELEASE, 5, 0, 4, 1, 32'hFFFF_FF00, 32'h100, 5);
    direct(bfa_pkg::OP_FLUSH, 6, 0, 4, 0, 0, 0, 0);
    direct(bfa_pkg::OP_ALLOC, 6, 32'h0040_0000, 4, 0, 0, 0, 0);

    for (int ph = 0; ph < 6; ph++) begin
      wait_idle();
      case (ph)
        0: begin
          write_reg(bfa_pkg::REG_FRAMES, 1);
          write_reg(bfa_pkg::REG_CAPACITY, 4096);
        end
        1: begin
          write_reg(bfa_pkg::REG_FRAMES, 0);
          write_reg(bfa_pkg::REG_CAPACITY, 32'hFFFF_FFFF);
        end
        2: begin
          write_reg(bfa_pkg::REG_FRAMES, 255);
          write_reg(bfa_pkg::REG_CAPACITY, 64);
        end
        3: begin
          write_reg(bfa_pkg::REG_FRAMES, 2);
          write_reg(bfa_pkg::REG_CAPACITY, 4);
        end
        4: begin
          write_reg(bfa_pkg::REG_FRAMES, 3);
          write_reg(bfa_pkg::REG_CAPACITY, 65536);
        end
        default: begin
          write_reg(bfa_pkg::REG_FRAMES, 4);
          write_reg(bfa_pkg::REG_CAPACITY, 1 << 20);
        end
      endcase
      now = (ph == 1) ? 32'hFFFF_FFC0 : $urandom;
      for (int k = 0; k < 85; k++) random_word((ph == 2 || ph == 4) ? 25 : 0);
    end

    wait_idle();
    repeat (200) @(posedge clk);
    $display("Sent %0d request words over six configurations; checked %0d results.",
             n_sent, sb.checked);
    $display("Grants %0d, no-fit %0d, table-full %0d, mismatches %0d.",
             sb.grants, sb.no_fits, sb.fulls, sb.errors);
    if (sb.errors == 0 && sb.awaited.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

`default_nettype wire

// ===== best_fit_deferred_free_allocator.f =====
src/bfa_pkg.sv
src/bfa_rem.sv
src/best_fit_deferred_free_allocator.sv
sim/tb.sv
